// ===== sv/sbrp_pkg.sv =====
// Package for the STUN binding response parser.
// Holds the shared constants, codes and record types; no dependencies.
package sbrp_pkg;

	// Fixed message layout.
	localparam int unsigned HDR_BYTES = 20;
	localparam logic [31:0] STUN_COOKIE = 32'h2112_A442;
	localparam logic [15:0] COOKIE_PORT_MASK = 16'h2112;

	// Attribute types of interest.
	localparam logic [15:0] ATTR_MAPPED = 16'h0001;
	localparam logic [15:0] ATTR_XOR = 16'h0020;
	localparam logic [15:0] ATTR_MS_XOR = 16'h8020;
	localparam logic [7:0] FAMILY_IPV4 = 8'h01;
	localparam logic [15:0] ADDR_VALUE_BYTES = 16'd8;

	// Width of the packed result transfer.
	localparam int unsigned RESULT_BITS = 72;

	// Completion status codes.
	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SHORT = 2'd1,
		ST_BAD_COOKIE = 2'd2,
		ST_LEN_OVERRUN = 2'd3
	} status_t;

	// Kind of the kept address, ordered by preference.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_MAPPED = 2'd1,
		KIND_MS_XOR = 2'd2,
		KIND_XOR = 2'd3
	} addr_kind_t;

	// Position inside the attribute walk.
	typedef enum logic [2:0] {
		PH_TYPE_HI = 3'd0,
		PH_TYPE_LO = 3'd1,
		PH_LEN_HI = 3'd2,
		PH_LEN_LO = 3'd3,
		PH_VALUE = 3'd4
	} attr_phase_t;

	// Raw outcome of one payload, passed from the parser to the formatter.
	typedef struct packed {
		status_t status;
		addr_kind_t kind;
		logic [31:0] ip;
		logic [15:0] port;
		logic [15:0] msg_type;
	} frame_rec_t;

endpackage

// ===== sv/stun_binding_response_parser.sv =====
// STUN binding response parser top level; depends on sbrp_pkg, sbrp_front, sbrp_queue, sbrp_back.
// Throughput: one byte per cycle; the input stalls only while both record queue entries wait
// behind a result in the output register that the receiver has not yet taken.
// Result path: the record is written into the record queue by the edge that accepts the last byte;
// it then moves into the output register once that is free, and sits there until taken.
// Reset (arst_n, asynchronous, active low) clears the parse state, queue and output valid.
module stun_binding_response_parser #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [7:0] s_axis_tdata, // [7:0] byte_value
	input logic s_axis_tlast, // last_byte
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// [1:0] status, [2] address_found, [4:3] address_kind, [36:5] mapped_ip,
	// [52:37] mapped_port, [54:53] message_class, [66:55] message_method, rest zero
	output logic [sbrp_pkg::RESULT_BITS-1:0] m_axis_tdata
);

	logic rec_full;
	logic rec_push;
	sbrp_pkg::frame_rec_t rec;
	logic head_valid;
	sbrp_pkg::frame_rec_t head_rec;
	logic pop;

	// Byte parser.
	sbrp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_byte(s_axis_tdata),
		.in_last(s_axis_tlast),
		.in_ready(s_axis_tready),
		.rec_full(rec_full),
		.rec_push(rec_push),
		.rec(rec)
	);

	// Record queue.
	sbrp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(rec_push),
		.push_rec(rec),
		.full(rec_full),
		.pop(pop),
		.head_valid(head_valid),
		.head_rec(head_rec)
	);

	// Result formatter.
	sbrp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_rec(head_rec),
		.pop(pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);

endmodule

// ===== sv/sbrp_front.sv =====
// Byte parser: header capture, attribute walk and best-address selection.
// Depends on sbrp_pkg; emits one frame record per payload on its last byte.
module sbrp_front #(
	parameter int unsigned LENGTH_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	input logic in_last,
	output logic in_ready,
	input logic rec_full,
	output logic rec_push,
	output sbrp_pkg::frame_rec_t rec
);

	localparam int unsigned CW = 17;
	localparam logic [LENGTH_BITS-1:0] IDX_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] IDX_HDR = LENGTH_BITS'(sbrp_pkg::HDR_BYTES);

	logic [LENGTH_BITS-1:0] byte_index_q, byte_index_nx;
	logic [15:0] msg_type_q, msg_type_nx;
	logic [15:0] msg_len_q, msg_len_nx;
	logic [31:0] cookie_q, cookie_nx;
	sbrp_pkg::attr_phase_t phase_q, phase_nx;
	logic [15:0] atype_q, atype_nx;
	logic [15:0] alen_q, alen_nx;
	logic [15:0] aoff_q, aoff_nx;
	logic stopped_q, stopped_nx;
	logic [7:0] cfam_q, cfam_nx;
	logic [15:0] cport_q, cport_nx;
	logic [31:0] cip_q, cip_nx;
	sbrp_pkg::addr_kind_t bkind_q, bkind_nx;
	logic [15:0] bport_q, bport_nx;
	logic [31:0] bip_q, bip_nx;

	logic take;
	logic counting;
	logic walk_en;
	logic [LENGTH_BITS-1:0] pos;
	logic [15:0] rem;
	logic [15:0] len_full;
	logic [15:0] aoff_inc;
	logic len_over;
	logic rem_short;
	logic value_done;
	sbrp_pkg::addr_kind_t cand_kind;
	logic [CW-1:0] body_bytes;

	assign in_ready = !rec_full;
	assign take = in_valid && in_ready;
	assign counting = (byte_index_q != IDX_MAX);

	// Shared quantities of the attribute walk.
	assign pos = byte_index_q - IDX_HDR;
	assign rem = 16'(CW'(msg_len_q) - CW'(pos));
	assign len_full = {alen_q[15:8], in_byte};
	assign aoff_inc = aoff_q + 16'd1;
	assign len_over = (len_full > (rem - 16'd1));
	assign rem_short = (rem < 16'd4);
	assign value_done = (aoff_inc == alen_q);
	assign walk_en = counting && (byte_index_q >= IDX_HDR) && !stopped_q
		&& (CW'(pos) < CW'(msg_len_q));

	// Kind that the current attribute would give.
	always_comb begin
		unique case (atype_q)
			sbrp_pkg::ATTR_XOR: cand_kind = sbrp_pkg::KIND_XOR;
			sbrp_pkg::ATTR_MS_XOR: cand_kind = sbrp_pkg::KIND_MS_XOR;
			sbrp_pkg::ATTR_MAPPED: cand_kind = sbrp_pkg::KIND_MAPPED;
			default: cand_kind = sbrp_pkg::KIND_NONE;
		endcase
	end

	// Next walk phase.
	always_comb begin
		phase_nx = phase_q;
		if (walk_en) begin
			unique case (phase_q)
				sbrp_pkg::PH_TYPE_HI: begin
					if (!rem_short) phase_nx = sbrp_pkg::PH_TYPE_LO;
				end
				sbrp_pkg::PH_TYPE_LO: phase_nx = sbrp_pkg::PH_LEN_HI;
				sbrp_pkg::PH_LEN_HI: phase_nx = sbrp_pkg::PH_LEN_LO;
				sbrp_pkg::PH_LEN_LO: begin
					if (!len_over) begin
						phase_nx = (len_full == 16'd0) ? sbrp_pkg::PH_TYPE_HI
							: sbrp_pkg::PH_VALUE;
					end
				end
				sbrp_pkg::PH_VALUE: begin
					if (value_done) phase_nx = sbrp_pkg::PH_TYPE_HI;
				end
				default: begin
					if (!rem_short) phase_nx = sbrp_pkg::PH_TYPE_LO;
				end
			endcase
		end
	end

	// Header capture, attribute fields and address selection.
	always_comb begin
		byte_index_nx = byte_index_q;
		msg_type_nx = msg_type_q;
		msg_len_nx = msg_len_q;
		cookie_nx = cookie_q;
		atype_nx = atype_q;
		alen_nx = alen_q;
		aoff_nx = aoff_q;
		stopped_nx = stopped_q;
		cfam_nx = cfam_q;
		cport_nx = cport_q;
		cip_nx = cip_q;
		bkind_nx = bkind_q;
		bport_nx = bport_q;
		bip_nx = bip_q;
		if (counting) begin
			byte_index_nx = byte_index_q + LENGTH_BITS'(1);
			if (byte_index_q < LENGTH_BITS'(2)) begin
				msg_type_nx = {msg_type_q[7:0], in_byte};
			end else if (byte_index_q < LENGTH_BITS'(4)) begin
				msg_len_nx = {msg_len_q[7:0], in_byte};
			end else if (byte_index_q < LENGTH_BITS'(8)) begin
				cookie_nx = {cookie_q[23:0], in_byte};
			end
		end
		if (walk_en) begin
			unique case (phase_q)
				sbrp_pkg::PH_TYPE_LO: atype_nx = {atype_q[15:8], in_byte};
				sbrp_pkg::PH_LEN_HI: alen_nx = {in_byte, 8'h00};
				sbrp_pkg::PH_LEN_LO: begin
					if (len_over) begin
						stopped_nx = 1'b1;
					end else begin
						alen_nx = len_full;
						cfam_nx = 8'h00;
						cport_nx = 16'h0000;
						cip_nx = 32'h0000_0000;
						aoff_nx = 16'h0000;
					end
				end
				sbrp_pkg::PH_VALUE: begin
					if (aoff_q == 16'd1) begin
						cfam_nx = in_byte;
					end else if (aoff_q == 16'd2) begin
						cport_nx = {in_byte, 8'h00};
					end else if (aoff_q == 16'd3) begin
						cport_nx = {cport_q[15:8], in_byte};
					end else if (aoff_q >= 16'd4 && aoff_q < 16'd8) begin
						cip_nx = {cip_q[23:0], in_byte};
					end
					aoff_nx = aoff_inc;
					// The attribute ends here: keep it if it holds an IPv4 address of at least 8 value bytes and is at least as good.
					if (value_done && cand_kind != sbrp_pkg::KIND_NONE
							&& cand_kind >= bkind_q
							&& alen_q >= sbrp_pkg::ADDR_VALUE_BYTES
							&& cfam_nx == sbrp_pkg::FAMILY_IPV4) begin
						bkind_nx = cand_kind;
						if (cand_kind == sbrp_pkg::KIND_MAPPED) begin
							bport_nx = cport_nx;
							bip_nx = cip_nx;
						end else begin
							bport_nx = cport_nx ^ sbrp_pkg::COOKIE_PORT_MASK;
							bip_nx = cip_nx ^ sbrp_pkg::STUN_COOKIE;
						end
					end
				end
				default: begin
					if (rem_short) stopped_nx = 1'b1;
					else atype_nx = {in_byte, 8'h00};
				end
			endcase
		end
	end

	// Outcome of the payload, judged on the state after the last byte.
	assign body_bytes = CW'(byte_index_nx) - CW'(sbrp_pkg::HDR_BYTES);
	always_comb begin
		rec.kind = bkind_nx;
		rec.ip = bip_nx;
		rec.port = bport_nx;
		rec.msg_type = msg_type_nx;
		if (byte_index_nx < IDX_HDR) begin
			rec.status = sbrp_pkg::ST_SHORT;
		end else if (cookie_nx != sbrp_pkg::STUN_COOKIE) begin
			rec.status = sbrp_pkg::ST_BAD_COOKIE;
		end else if (CW'(msg_len_nx) > body_bytes) begin
			rec.status = sbrp_pkg::ST_LEN_OVERRUN;
		end else begin
			rec.status = sbrp_pkg::ST_OK;
		end
	end
	assign rec_push = take && in_last;

	// State update; the last byte returns everything to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			msg_type_q <= '0;
			msg_len_q <= '0;
			cookie_q <= '0;
			phase_q <= sbrp_pkg::PH_TYPE_HI;
			atype_q <= '0;
			alen_q <= '0;
			aoff_q <= '0;
			stopped_q <= 1'b0;
			cfam_q <= '0;
			cport_q <= '0;
			cip_q <= '0;
			bkind_q <= sbrp_pkg::KIND_NONE;
			bport_q <= '0;
			bip_q <= '0;
		end else if (take) begin
			if (in_last) begin
				byte_index_q <= '0;
				msg_type_q <= '0;
				msg_len_q <= '0;
				cookie_q <= '0;
				phase_q <= sbrp_pkg::PH_TYPE_HI;
				atype_q <= '0;
				alen_q <= '0;
				aoff_q <= '0;
				stopped_q <= 1'b0;
				cfam_q <= '0;
				cport_q <= '0;
				cip_q <= '0;
				bkind_q <= sbrp_pkg::KIND_NONE;
				bport_q <= '0;
				bip_q <= '0;
			end else begin
				byte_index_q <= byte_index_nx;
				msg_type_q <= msg_type_nx;
				msg_len_q <= msg_len_nx;
				cookie_q <= cookie_nx;
				phase_q <= phase_nx;
				atype_q <= atype_nx;
				alen_q <= alen_nx;
				aoff_q <= aoff_nx;
				stopped_q <= stopped_nx;
				cfam_q <= cfam_nx;
				cport_q <= cport_nx;
				cip_q <= cip_nx;
				bkind_q <= bkind_nx;
				bport_q <= bport_nx;
				bip_q <= bip_nx;
			end
		end
	end

endmodule

// ===== sv/sbrp_queue.sv =====
// Two-entry queue of frame records between the parser and the formatter.
// Depends on sbrp_pkg for the record type.
module sbrp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input sbrp_pkg::frame_rec_t push_rec,
	output logic full,
	input logic pop,
	output logic head_valid,
	output sbrp_pkg::frame_rec_t head_rec
);

	sbrp_pkg::frame_rec_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_rec = slot_q[rd_ptr_q];

	// Record storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_rec;
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

// ===== sv/sbrp_back.sv =====
// Result formatter: decodes class and method, zeroes fields on error and
// holds the packed result in an output register. Depends on sbrp_pkg.
module sbrp_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input sbrp_pkg::frame_rec_t head_rec,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [sbrp_pkg::RESULT_BITS-1:0] out_data
);

	logic out_valid_q;
	logic [sbrp_pkg::RESULT_BITS-1:0] out_data_q;
	logic [sbrp_pkg::RESULT_BITS-1:0] packed_res;
	logic ok;
	logic found;
	logic [1:0] type_class;
	logic [11:0] msg_method;

	// Decode the message type, skipping the interleaved class bits.
	assign ok = (head_rec.status == sbrp_pkg::ST_OK);
	assign found = (head_rec.kind != sbrp_pkg::KIND_NONE);
	assign type_class = {head_rec.msg_type[8], head_rec.msg_type[4]};
	assign msg_method = {head_rec.msg_type[13:9], head_rec.msg_type[7:5],
		head_rec.msg_type[3:0]};

	// Pack the result; an error status clears every other field.
	always_comb begin
		packed_res = '0;
		packed_res[1:0] = head_rec.status;
		if (ok) begin
			packed_res[2] = found;
			packed_res[4:3] = head_rec.kind;
			packed_res[36:5] = head_rec.ip;
			packed_res[52:37] = head_rec.port;
			packed_res[54:53] = type_class;
			packed_res[66:55] = msg_method;
		end
	end

	assign pop = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_data_q <= packed_res;
	end

endmodule
